// ----- hw/rtl/swfrm_pkg.sv -----
// Package for the sliding-window frame rate meter.
// Shared constants: ring depth default, window scaling, divider widths, item modes.
package swfrm_pkg;

  localparam int unsigned DEPTH_DEFAULT   = 64;
  localparam int unsigned TS_W            = 64;
  localparam int unsigned WIN_MS_W        = 23;
  localparam int unsigned WIN_US_W        = 33;
  localparam int unsigned RATE_W          = 32;
  localparam int unsigned COUNT_W         = 7;
  localparam int unsigned FRAC_W          = 16;
  localparam int unsigned US_PER_MS       = 1000;
  localparam int unsigned US_PER_SEC      = 1000000;
  localparam int unsigned US_PER_SEC_W    = 20;
  localparam int unsigned WIN_MS_RESET    = 3000;
  localparam int unsigned DIV_STEP_W      = 5;

  localparam logic [WIN_US_W-1:0] WIN_US_RESET = WIN_US_W'(WIN_MS_RESET * US_PER_MS);

  // input item mode, carried on tuser
  typedef enum logic {
    MODE_MARK  = 1'b0,
    MODE_QUERY = 1'b1
  } item_mode_e;

endpackage

// ----- hw/rtl/swfrm_ring.sv -----
// Timestamp ring for the frame rate meter: one write port, one registered read.
// Tracks the write slot and a fill flag so never-written slots read as zero.
// Depends on swfrm_pkg.
module swfrm_ring #(
  parameter int unsigned DEPTH = swfrm_pkg::DEPTH_DEFAULT,
  localparam int unsigned IW   = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [swfrm_pkg::TS_W-1:0]   push_data_i,
  input  logic                         rd_en_i,
  input  logic [IW-1:0]                rd_addr_i,
  output logic [swfrm_pkg::TS_W-1:0]   rd_data_o,
  output logic [IW-1:0]                wr_slot_o
);

  logic [swfrm_pkg::TS_W-1:0] mem_q [DEPTH];
  logic [swfrm_pkg::TS_W-1:0] rd_data_q;
  logic [IW-1:0]              wr_slot_q, wr_slot_d;
  logic                       full_q, full_d;
  logic                       rd_written_q;

  always_comb begin
    wr_slot_d = wr_slot_q;
    full_d    = full_q;
    if (push_i) begin
      if (wr_slot_q == IW'(DEPTH - 1)) begin
        wr_slot_d = '0;
        full_d    = 1'b1;
      end else begin
        wr_slot_d = wr_slot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_slot_q] <= push_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_slot_q    <= '0;
      full_q       <= 1'b0;
      rd_written_q <= 1'b0;
    end else begin
      wr_slot_q <= wr_slot_d;
      full_q    <= full_d;
      if (rd_en_i) begin
        // slots below the write slot are written until the ring first wraps
        rd_written_q <= full_q || (rd_addr_i < wr_slot_q);
      end
    end
  end

  assign rd_data_o = rd_written_q ? rd_data_q : '0;
  assign wr_slot_o = wr_slot_q;

endmodule

// ----- hw/rtl/swfrm_div.sv -----
// Restoring divider for the rate: 64-bit dividend by 64-bit divisor,
// 32-bit quotient, one bit per cycle, saturating. Depends on swfrm_pkg.
module swfrm_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [swfrm_pkg::TS_W-1:0]     num_i,
  input  logic [swfrm_pkg::TS_W-1:0]     den_i,
  output logic                           done_o,
  output logic [swfrm_pkg::RATE_W-1:0]   quo_o
);

  localparam int unsigned TW = swfrm_pkg::TS_W;
  localparam int unsigned QW = swfrm_pkg::RATE_W;

  logic                               busy_q;
  logic                               done_q;
  logic [swfrm_pkg::DIV_STEP_W-1:0]   step_q;
  logic [TW-1:0]                      rem_q;
  logic [TW-1:0]                      den_q;
  logic [QW-1:0]                      quo_q;
  logic [TW:0]                        rem_sh;
  logic [TW:0]                        rem_sub;
  logic                               fits;

  assign rem_sh  = {rem_q, quo_q[QW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign fits    = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      if (TW'(num_i[TW-1:QW]) >= den_i) begin
        // quotient would need more than 32 bits, or the divisor is zero
        quo_q <= '1;
      end else begin
        rem_q <= TW'(num_i[TW-1:QW]);
        quo_q <= num_i[QW-1:0];
      end
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[TW-1:0] : rem_sh[TW-1:0];
      quo_q <= {quo_q[QW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        step_q <= '0;
        if (TW'(num_i[TW-1:QW]) >= den_i) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == swfrm_pkg::DIV_STEP_W'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- hw/rtl/sliding_window_frame_rate_meter_unit.sv -----
// Sliding-window frame rate meter: top level with the query sequencer.
// Timing: a mark item is stored in the cycle it is accepted; a query reads the
// newest entry, then walks forward over stale ring entries (up to DEPTH-1 skipped),
// then forms the product and runs the 32-step serial divide.
// Marks go one per cycle; no item is taken while a query runs, until its result is loaded.
// Reset (rst_ni, async, active low) empties the ring and sets window_ms to 3000.
module sliding_window_frame_rate_meter_unit #(
  parameter int unsigned DEPTH = swfrm_pkg::DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: window length in milliseconds
  input  logic        cfg_we_i,
  input  logic [22:0] cfg_wdata_i,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [63:0] timestamp
  input  logic [0:0]  s_axis_tuser_i,   // [0] mode: 0 mark, 1 query
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // [31:0] rate_fixed, [38:32] frame_count, [39] zero
);

  localparam int unsigned IW  = $clog2(DEPTH);
  localparam int unsigned FCW = $clog2(DEPTH + 1);
  localparam int unsigned PW  = FCW + swfrm_pkg::US_PER_SEC_W;
  localparam int unsigned TW  = swfrm_pkg::TS_W;
  localparam int unsigned RW  = swfrm_pkg::RATE_W;
  localparam int unsigned CW  = swfrm_pkg::COUNT_W;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LAST  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DSTRT = 3'd4;
  localparam logic [2:0] S_DWAIT = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                      state_q, state_d;
  logic [swfrm_pkg::WIN_US_W-1:0]  win_us_q;
  logic [TW-1:0]                   now_q, since_q, elapsed_q;
  logic [IW-1:0]                   first_q, last_q;
  logic [FCW-1:0]                  skip_q, frames_q;
  logic [PW-1:0]                   prod_q;
  logic [RW-1:0]                   rate_q;
  logic                            out_valid_q;
  logic [39:0]                     out_data_q;

  logic                            in_accept;
  logic                            push;
  logic                            rd_en;
  logic [IW-1:0]                   rd_addr;
  logic [TW-1:0]                   rd_data;
  logic [IW-1:0]                   wr_slot;
  logic [IW-1:0]                   last_slot;
  logic [IW-1:0]                   first_nxt;
  logic [FCW-1:0]                  frames_now;
  logic                            div_start;
  logic                            div_done;
  logic [RW-1:0]                   div_quo;
  logic [TW-1:0]                   div_num;
  logic                            out_load;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign push            = in_accept && (s_axis_tuser_i[0] == swfrm_pkg::MODE_MARK);

  // newest slot sits just behind the write slot
  assign last_slot  = (wr_slot == '0) ? IW'(DEPTH - 1) : wr_slot - 1'b1;
  assign first_nxt  = (first_q == IW'(DEPTH - 1)) ? '0 : first_q + 1'b1;
  // the walk starts at the oldest slot, so frames left = DEPTH minus skipped
  assign frames_now = FCW'(DEPTH) - skip_q;
  assign div_start  = (state_q == S_DSTRT);
  assign div_num    = TW'(prod_q) << swfrm_pkg::FRAC_W;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || m_axis_tready_i);

  // pick the ring read address for the next compare
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = first_q;
    case (state_q)
      S_IDLE: begin
        rd_en   = in_accept && (s_axis_tuser_i[0] != swfrm_pkg::MODE_MARK);
        rd_addr = last_slot;
      end
      S_LAST: begin
        rd_en   = 1'b1;
        rd_addr = first_q;
      end
      S_WALK: begin
        rd_en   = 1'b1;
        rd_addr = first_nxt;
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = first_q;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept && (s_axis_tuser_i[0] != swfrm_pkg::MODE_MARK)) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        // newest frame already outside the window: report nothing counted
        state_d = (rd_data < since_q) ? S_DONE : S_WALK;
      end
      S_WALK: begin
        if (!((first_q != last_q) && (rd_data < since_q))) begin
          state_d = (frames_now <= FCW'(1)) ? S_DONE : S_MUL;
        end
      end
      S_MUL:   state_d = S_DSTRT;
      S_DSTRT: state_d = S_DWAIT;
      S_DWAIT: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        now_q   <= s_axis_tdata_i;
        since_q <= s_axis_tdata_i - TW'(win_us_q);
        first_q <= wr_slot;
        last_q  <= last_slot;
        skip_q  <= '0;
      end
      S_LAST: begin
        if (rd_data < since_q) begin
          rate_q   <= '0;
          frames_q <= '0;
        end
      end
      S_WALK: begin
        if ((first_q != last_q) && (rd_data < since_q)) begin
          // drop the stale entry and advance
          first_q <= first_nxt;
          skip_q  <= skip_q + 1'b1;
        end else begin
          frames_q  <= frames_now;
          elapsed_q <= now_q - rd_data;
          rate_q    <= '0;
        end
      end
      S_MUL: begin
        prod_q <= PW'(frames_q) * PW'(swfrm_pkg::US_PER_SEC);
      end
      S_DWAIT: begin
        if (div_done) begin
          rate_q <= div_quo;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_data_q <= {1'b0, CW'(frames_q), rate_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_us_q    <= swfrm_pkg::WIN_US_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        // keep the window in microseconds, full width
        win_us_q <= swfrm_pkg::WIN_US_W'(cfg_wdata_i) *
                    swfrm_pkg::WIN_US_W'(swfrm_pkg::US_PER_MS);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  swfrm_ring #(
    .DEPTH(DEPTH)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(s_axis_tdata_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .wr_slot_o  (wr_slot)
  );

  swfrm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (elapsed_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
